// ===== hdl/ppss_pkg.sv =====
package ppss_pkg;

    localparam int CLOCK_HZ = 72000000;
    localparam int CAND_N   = 10;

    localparam int CLK_W = $clog2(CLOCK_HZ + 1);
    localparam int SQ_W  = (CLK_W + 1) / 2;
    localparam int DIV_W = 16;
    localparam int F_W   = 16;
    localparam int OUT_W = 16;
    localparam int ERR_W = CLK_W + 1;

    localparam logic [CLK_W-1:0] CLK_VAL       = CLK_W'(CLOCK_HZ);
    localparam logic [F_W-1:0]   DEFAULT_FREQ  = F_W'(50);
    localparam logic [SQ_W-1:0]  START_BACKOFF = SQ_W'(5);
    localparam logic [DIV_W-1:0] EMPTY_PERIOD  = DIV_W'(999);
    localparam logic [OUT_W-1:0] SAT_MAX       = '1;

    function automatic logic [OUT_W-1:0] sat_err(input logic [ERR_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > ERR_W'(SAT_MAX))
            r = SAT_MAX;
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/ppss_div.sv =====
module ppss_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ppss_pkg::CLK_W-1:0]    num,
    input  logic [ppss_pkg::DIV_W-1:0]    den,
    output logic [ppss_pkg::CLK_W-1:0]    quo
);
    import ppss_pkg::*;

    // One quotient bit per stage, restoring division. The dividend word shifts
    // left and the quotient bits fill in from the bottom.
    logic [CLK_W-1:0] num_reg [CLK_W];
    logic [DIV_W-1:0] rem_reg [CLK_W-1];
    logic [DIV_W-1:0] den_reg [CLK_W-1];

    logic [CLK_W-1:0] num_next [CLK_W];
    logic [DIV_W-1:0] rem_next [CLK_W];
    logic [DIV_W-1:0] den_next [CLK_W];

    always_comb
    begin
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] r_in;
        logic [DIV_W-1:0] d_in;
        logic [CLK_W-1:0] n_in;
        for (int k = 0; k < CLK_W; k++)
        begin
            if (k == 0)
            begin
                r_in = '0;
                d_in = den;
                n_in = num;
            end
            else
            begin
                r_in = rem_reg[k-1];
                d_in = den_reg[k-1];
                n_in = num_reg[k-1];
            end
            trial = {r_in, n_in[CLK_W-1]};
            if (trial >= {1'b0, d_in})
            begin
                rem_next[k] = DIV_W'(trial - {1'b0, d_in});
                num_next[k] = {n_in[CLK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DIV_W-1:0];
                num_next[k] = {n_in[CLK_W-2:0], 1'b0};
            end
            den_next[k] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < CLK_W; k++)
                num_reg[k] <= num_next[k];
            for (int k = 0; k < CLK_W - 1; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = num_reg[CLK_W-1];

endmodule

// ===== hdl/ppss_sqrt.sv =====
module ppss_sqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ppss_pkg::CLK_W-1:0]    val,
    output logic [ppss_pkg::SQ_W-1:0]     root
);
    import ppss_pkg::*;

    localparam int R_W = SQ_W + 2;
    localparam int V_W = 2 * SQ_W;

    // One root bit per stage, taking two radicand bits at a time.
    logic [V_W-1:0]  v_reg [SQ_W-1];
    logic [SQ_W-1:0] r_reg [SQ_W-1];
    logic [SQ_W-1:0] y_reg [SQ_W];

    logic [V_W-1:0]  v_next [SQ_W];
    logic [SQ_W-1:0] r_next [SQ_W];
    logic [SQ_W-1:0] y_next [SQ_W];

    always_comb
    begin
        logic [R_W-1:0]  rsh;
        logic [R_W-1:0]  trial;
        logic [R_W-1:0]  diff;
        logic [V_W-1:0]  v_in;
        logic [SQ_W-1:0] r_in;
        logic [SQ_W-1:0] y_in;
        for (int k = 0; k < SQ_W; k++)
        begin
            if (k == 0)
            begin
                v_in = V_W'(val);
                r_in = '0;
                y_in = '0;
            end
            else
            begin
                v_in = v_reg[k-1];
                r_in = r_reg[k-1];
                y_in = y_reg[k-1];
            end
            rsh   = {r_in, v_in[V_W-1:V_W-2]};
            trial = {y_in, 2'b01};
            diff  = rsh - trial;
            if (rsh >= trial)
            begin
                r_next[k] = diff[SQ_W-1:0];
                y_next[k] = {y_in[SQ_W-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = rsh[SQ_W-1:0];
                y_next[k] = {y_in[SQ_W-2:0], 1'b0};
            end
            v_next[k] = {v_in[V_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_W; k++)
                y_reg[k] <= y_next[k];
            for (int k = 0; k < SQ_W - 1; k++)
            begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = y_reg[SQ_W-1];

endmodule

// ===== hdl/pwm_prescaler_period_search_core.sv =====
// PWM prescaler and period search.
//
// Input channel s_*: one item per request, tdata carries the requested PWM
// frequency in hertz (zero selects 50 Hz). Output channel m_*: one item per
// request, in request order, carrying the prescaler and period register
// values (each already minus one) and the absolute frequency error.
//
// The block is a fixed pipeline: a divider for the clock over the frequency,
// a square root, a bank of dividers per candidate prescaler for the period
// and the achieved frequency, then one compare stage per candidate.
// Throughput is one item per cycle while s_tready is high; the divider
// stages set the depth.
//
// Reset clears all valid bits; the block then takes items at once.
// When the receiver stalls, the result register holds its item and the
// pipeline keeps moving until an item reaches its last stage, then s_tready
// drops until the output is taken.
module pwm_prescaler_period_search_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] target_frequency
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] prescaler_value, [31:16] period_value,
                                   // [47:32] frequency_error
);
    import ppss_pkg::*;

    localparam int LD  = CLK_W;
    localparam int B   = LD - 1 + SQ_W;
    localparam int C   = B + 1;
    localparam int E   = C + 2 * LD;
    localparam int F   = E + 1;
    localparam int TOT = F + CAND_N + 1;
    localparam int FD  = E + 1;

    logic             en;
    logic             out_load;
    logic [TOT-1:0]   vld_reg;
    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;

    logic [F_W-1:0]   f_eff;
    logic [F_W-1:0]   f_dly_reg [FD];
    logic [CLK_W-1:0] q_w;
    logic [SQ_W-1:0]  root_w;
    logic [CLK_W-1:0] q_dly_reg [SQ_W];

    logic [DIV_W-1:0] start_w;
    logic [DIV_W-1:0] p_reg [CAND_N];
    logic [CLK_W-1:0] qp_reg;

    logic [CLK_W-1:0] n_w   [CAND_N];
    logic [CLK_W-1:0] cp_w  [CAND_N];
    logic [CLK_W-1:0] ach_w [CAND_N];

    logic [DIV_W-1:0] p_dly_reg  [2*LD][CAND_N];
    logic [DIV_W-1:0] n_dly_reg  [LD][CAND_N];
    logic             nz_dly_reg [LD][CAND_N];

    logic [ERR_W-1:0] err_next [CAND_N];
    logic [ERR_W-1:0] err_reg  [CAND_N];
    logic [DIV_W-1:0] pe_reg   [CAND_N];
    logic [DIV_W-1:0] ne_reg   [CAND_N];
    logic             nze_reg  [CAND_N];

    // Compare chain: each stage carries every lane and the best so far.
    logic [ERR_W-1:0] ce_reg  [CAND_N][CAND_N];
    logic [DIV_W-1:0] cp_reg  [CAND_N][CAND_N];
    logic [DIV_W-1:0] cn_reg  [CAND_N][CAND_N];
    logic             cz_reg  [CAND_N][CAND_N];
    logic [ERR_W-1:0] be_reg  [CAND_N];
    logic [DIV_W-1:0] bp_reg  [CAND_N];
    logic [DIV_W-1:0] bn_reg  [CAND_N];
    logic             bz_reg  [CAND_N];
    logic [ERR_W-1:0] be_next [CAND_N];
    logic [DIV_W-1:0] bp_next [CAND_N];
    logic [DIV_W-1:0] bn_next [CAND_N];
    logic             bz_next [CAND_N];

    logic [DIV_W-1:0] fin_n;
    logic [47:0]      m_tdata_next;

    assign out_load = !m_tvalid_reg || m_tready;
    assign en       = out_load || !vld_reg[TOT-1];
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign f_eff = (s_tdata == '0) ? DEFAULT_FREQ : s_tdata;

    ppss_div u_div_q (.clk(clk), .en(en), .num(CLK_VAL), .den(f_eff), .quo(q_w));
    ppss_sqrt u_sqrt (.clk(clk), .en(en), .val(q_w), .root(root_w));

    assign start_w = (root_w > START_BACKOFF) ? DIV_W'(root_w - START_BACKOFF)
                                              : DIV_W'(1);

    for (genvar i = 0; i < CAND_N; i++)
    begin : g_lane
        ppss_div u_div_n (.clk(clk), .en(en), .num(qp_reg), .den(p_reg[i]), .quo(n_w[i]));
        ppss_div u_div_c (.clk(clk), .en(en), .num(CLK_VAL), .den(p_reg[i]),
                          .quo(cp_w[i]));
        // The period and the clock over the prescaler leave their dividers
        // in the same cycle, so both enter the last divider together.
        ppss_div u_div_a (.clk(clk), .en(en), .num(cp_w[i]),
                          .den(n_w[i][DIV_W-1:0]), .quo(ach_w[i]));
    end

    always_comb
    begin
        logic [CLK_W-1:0] fz;
        fz = CLK_W'(f_dly_reg[FD-1]);
        for (int i = 0; i < CAND_N; i++)
        begin
            if (nz_dly_reg[LD-1][i])
                err_next[i] = '1;
            else if (ach_w[i] > fz)
                err_next[i] = ERR_W'(ach_w[i] - fz);
            else
                err_next[i] = ERR_W'(fz - ach_w[i]);
        end
    end

    // The first candidate always takes the slot; later ones only on a
    // strictly smaller error, which keeps the first minimum.
    always_comb
    begin
        be_next[0] = err_reg[0];
        bp_next[0] = pe_reg[0];
        bn_next[0] = ne_reg[0];
        bz_next[0] = nze_reg[0];
        for (int k = 1; k < CAND_N; k++)
        begin
            if (ce_reg[k-1][k] < be_reg[k-1])
            begin
                be_next[k] = ce_reg[k-1][k];
                bp_next[k] = cp_reg[k-1][k];
                bn_next[k] = cn_reg[k-1][k];
                bz_next[k] = cz_reg[k-1][k];
            end
            else
            begin
                be_next[k] = be_reg[k-1];
                bp_next[k] = bp_reg[k-1];
                bn_next[k] = bn_reg[k-1];
                bz_next[k] = bz_reg[k-1];
            end
        end
    end

    always_comb
    begin
        fin_n = bz_reg[CAND_N-1] ? EMPTY_PERIOD : bn_reg[CAND_N-1];
        m_tdata_next = {sat_err(be_reg[CAND_N-1]), fin_n - DIV_W'(1),
                        bp_reg[CAND_N-1] - DIV_W'(1)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_dly_reg[0] <= f_eff;
            for (int k = 1; k < FD; k++)
                f_dly_reg[k] <= f_dly_reg[k-1];
            q_dly_reg[0] <= q_w;
            for (int k = 1; k < SQ_W; k++)
                q_dly_reg[k] <= q_dly_reg[k-1];
            qp_reg <= q_dly_reg[SQ_W-1];
            for (int i = 0; i < CAND_N; i++)
            begin
                p_reg[i]           <= start_w + DIV_W'(i);
                p_dly_reg[0][i]    <= p_reg[i];
                for (int k = 1; k < 2 * LD; k++)
                    p_dly_reg[k][i] <= p_dly_reg[k-1][i];
                n_dly_reg[0][i]    <= n_w[i][DIV_W-1:0];
                nz_dly_reg[0][i]   <= (n_w[i] == '0);
                for (int k = 1; k < LD; k++)
                begin
                    n_dly_reg[k][i]  <= n_dly_reg[k-1][i];
                    nz_dly_reg[k][i] <= nz_dly_reg[k-1][i];
                end
                err_reg[i] <= err_next[i];
                pe_reg[i]  <= p_dly_reg[2*LD-1][i];
                ne_reg[i]  <= n_dly_reg[LD-1][i];
                nze_reg[i] <= nz_dly_reg[LD-1][i];
                ce_reg[0][i] <= err_reg[i];
                cp_reg[0][i] <= pe_reg[i];
                cn_reg[0][i] <= ne_reg[i];
                cz_reg[0][i] <= nze_reg[i];
                for (int k = 1; k < CAND_N; k++)
                begin
                    ce_reg[k][i] <= ce_reg[k-1][i];
                    cp_reg[k][i] <= cp_reg[k-1][i];
                    cn_reg[k][i] <= cn_reg[k-1][i];
                    cz_reg[k][i] <= cz_reg[k-1][i];
                end
            end
            for (int k = 0; k < CAND_N; k++)
            begin
                be_reg[k] <= be_next[k];
                bp_reg[k] <= bp_next[k];
                bn_reg[k] <= bn_next[k];
                bz_reg[k] <= bz_next[k];
            end
        end
        if (out_load)
            m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[TOT-2:0], s_tvalid};
            if (out_load)
                m_tvalid_reg <= vld_reg[TOT-1];
        end
    end

endmodule

// ===== hdl/ppss_checker.sv =====
module ppss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A held result keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // An offered input item stays in place until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while waiting");

    // Input back-pressure only comes from a stalled, full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    // Reset empties the pipeline and leaves the input open.
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

endmodule

bind pwm_prescaler_period_search_core ppss_checker u_ppss_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== verif/pwm_prescaler_period_search_core_tb.sv =====
module pwm_prescaler_period_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CLOCK_HZ_TB = 72000000;
    localparam int CANDIDATES = 10;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [15:0] frequency_error;
        logic [15:0] period_value;
        logic [15:0] prescaler_value;
    } setting_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    logic [15:0] freq_queue[$];
    setting_t    expected_settings[$];
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          mismatches;
    bit          stimulus_done;

    pwm_prescaler_period_search_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint int_sqrt(input longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        return (v > 65535) ? 16'hffff : v[15:0];
    endfunction

    // Searches the candidate prescalers around the square root of the divide
    // ratio and keeps the first one with the smallest frequency error.
    function automatic setting_t search_setting(input logic [15:0] target);
        longint f, ratio, first_p, p, n, achieved, err;
        longint best_p, best_n, best_err;
        setting_t s;
        f = (target == 0) ? 50 : target;
        ratio = CLOCK_HZ_TB / f;
        first_p = int_sqrt(ratio);
        first_p = (first_p > 5) ? first_p - 5 : 1;
        best_p = 0;
        best_n = 0;
        best_err = 0;
        for (int i = 0; i < CANDIDATES; i++)
        begin
            p = first_p + i;
            n = ratio / p;
            if (n == 0)
                err = 64'h7fffffffffffffff;
            else
            begin
                achieved = (CLOCK_HZ_TB / p) / n;
                err = (achieved > f) ? achieved - f : f - achieved;
            end
            if (i == 0 || err < best_err)
            begin
                best_p = p;
                best_n = n;
                best_err = err;
            end
        end
        if (best_n == 0)
            best_n = 999;
        s.prescaler_value = clip16(best_p - 1);
        s.period_value = clip16(best_n - 1);
        s.frequency_error = clip16(best_err);
        return s;
    endfunction

    // Driver: presents queued items, holding each until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_settings = {expected_settings, search_setting(s_tdata)};
            if (!s_tvalid || s_tready)
            begin
                if (freq_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= freq_queue.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        setting_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_settings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: prescaler %0d/%0d period %0d/%0d error %0d/%0d",
                                want.prescaler_value, got.prescaler_value,
                                want.period_value, got.period_value,
                                want.frequency_error, got.frequency_error);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        logic [15:0] freq;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(5))
                0: freq = 16'($urandom_range(65535));
                1: freq = 16'($urandom_range(1, 100));
                2: freq = 16'($urandom_range(100, 5000));
                3: freq = 16'($urandom_range(15) << $urandom_range(12));
                default: freq = 16'($urandom());
            endcase
            freq_queue = {freq_queue, freq};
        end
        while (freq_queue.size() > 0 || s_tvalid)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] directed[$];
        mismatches = 0;
        stimulus_done = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // Zero selects 50 Hz; the list also covers the lowest and highest frequencies.
        directed = '{16'd0, 16'd1, 16'd2, 16'd50, 16'd60, 16'd1000, 16'd1099,
                     16'd20000, 16'd32768, 16'd40000, 16'd65534, 16'd65535,
                     16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'd3, 16'd7};
        foreach (directed[i])
            freq_queue = {freq_queue, directed[i]};
        while (freq_queue.size() > 0 || s_tvalid)
            @(posedge clk);
        run_phase(475, 0, 0);
        run_phase(475, 69, 0);
        run_phase(475, 0, 69);
        run_phase(475, 21, 21);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        while (expected_settings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_settings.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ppss_pkg.sv
hdl/ppss_div.sv
hdl/ppss_sqrt.sv
hdl/pwm_prescaler_period_search_core.sv
hdl/ppss_checker.sv
verif/pwm_prescaler_period_search_core_tb.sv
